// ===== rtl/core/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg: shared types, constants and helpers of the 3x3 matrix inverse
// Payload structs of both channels, the divider word and the 32-bit clamp.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int DW     = 32;  // entry width
    localparam int PW     = 64;  // product of two entries
    localparam int NW     = 65;  // cofactor, signed
    localparam int NUM_W  = 64;  // cofactor magnitude
    localparam int DETW   = 97;  // determinant, signed
    localparam int MAGD_W = 96;  // determinant magnitude
    localparam int YW     = 97;  // divisor, twice the determinant magnitude
    localparam int QW     = 33;  // quotient bits kept before the clamp
    localparam int LANES  = 9;

    localparam logic [DW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

    // operand indices of each adjugate cofactor: a*b - c*d
    localparam int COF_IDX [LANES][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] inv00;
        logic signed [DW-1:0] inv01;
        logic signed [DW-1:0] inv02;
        logic signed [DW-1:0] inv10;
        logic signed [DW-1:0] inv11;
        logic signed [DW-1:0] inv12;
        logic signed [DW-1:0] inv20;
        logic signed [DW-1:0] inv21;
        logic signed [DW-1:0] inv22;
        logic signed [DW-1:0] det_value;
        logic                 singular;
    } out_t;

    typedef struct packed {
        logic [YW-1:0] rem;
        logic [QW-1:0] xb;
        logic [QW-1:0] q;
        logic          neg;
        logic          ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [YW-1:0]         y;
        logic                  singular;
        logic [DW-1:0]         det_value;
    } div_word_t;

    // clamp a sign and magnitude to a 32-bit two's complement value
    function automatic logic [DW-1:0] sat32(input logic neg, input logic [127:0] mag);
        logic [DW-1:0] r;
        if (!neg)
        begin
            r = (mag > 128'(SAT_MAX)) ? SAT_MAX : mag[DW-1:0];
        end
        else
        begin
            r = (mag > 128'(SAT_MIN)) ? SAT_MIN : (~mag[DW-1:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/m3i_stream_if.sv =====
// ----------------------------------------------------------------------------
// m3i_stream_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface m3i_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Seven register stages: products, cofactors, split det products, det terms,
// det sum, magnitudes and dividends, divider range check.
// ----------------------------------------------------------------------------
module m3i_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                en,
    input  m3i_pkg::in_t        din,
    output m3i_pkg::div_word_t  dout
);
    import m3i_pkg::*;

    localparam int SH = 2 * FRAC_BITS;
    localparam int XW = ((NUM_W + 1 + SH > MAGD_W) ? NUM_W + 1 + SH : MAGD_W) + 1;
    localparam int CW = (XW > YW + QW) ? XW : YW + QW;

    logic signed [DW-1:0]   m [LANES];

    logic signed [PW-1:0]   pa_reg [LANES];
    logic signed [PW-1:0]   pb_reg [LANES];
    logic signed [DW-1:0]   r0_reg [3];
    logic signed [NW-1:0]   cof1_reg [LANES];
    logic signed [DW-1:0]   r1_reg [3];
    logic signed [NW-1:0]   cof2_reg [LANES];
    logic signed [NW-1:0]   plo_reg [3];
    logic signed [NW-1:0]   phi_reg [3];
    logic signed [NW-1:0]   cof3_reg [LANES];
    logic signed [DETW-1:0] term_reg [3];
    logic signed [NW-1:0]   cof4_reg [LANES];
    logic signed [DETW-1:0] det_reg;
    logic [XW-1:0]          x5_reg [LANES];
    logic                   neg5_reg [LANES];
    logic [YW-1:0]          y5_reg;
    logic                   sing5_reg;
    logic [DW-1:0]          dval5_reg;
    div_word_t              f6_reg;

    logic                   dneg;
    logic signed [DETW-1:0] det_abs;
    logic [MAGD_W-1:0]      magd;
    logic [MAGD_W:0]        rnd;
    logic [MAGD_W:0]        rnd_sh;
    logic signed [NW-1:0]   cabs [LANES];
    logic [XW-1:0]          x_c [LANES];
    logic [CW-1:0]          xc6 [LANES];
    logic [CW-1:0]          rem6 [LANES];
    logic [CW-1:0]          ylim;

    assign m[0] = din.m00;
    assign m[1] = din.m01;
    assign m[2] = din.m02;
    assign m[3] = din.m10;
    assign m[4] = din.m11;
    assign m[5] = din.m12;
    assign m[6] = din.m20;
    assign m[7] = din.m21;
    assign m[8] = din.m22;

    // stages 0 to 4: cofactors and determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                pa_reg[k]   <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
                pb_reg[k]   <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
                cof1_reg[k] <= NW'(pa_reg[k]) - NW'(pb_reg[k]);
                cof2_reg[k] <= cof1_reg[k];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                r0_reg[j]   <= m[j];
                r1_reg[j]   <= r0_reg[j];
                plo_reg[j]  <= $signed({1'b0, cof1_reg[3*j][DW-1:0]}) * r1_reg[j];
                phi_reg[j]  <= $signed(cof1_reg[3*j][NW-1:DW]) * r1_reg[j];
                term_reg[j] <= (DETW'(phi_reg[j]) <<< DW) + DETW'(plo_reg[j]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    // stage 5: magnitudes, rounded determinant, dividends
    always_comb
    begin
        dneg    = det_reg[DETW-1];
        det_abs = dneg ? -det_reg : det_reg;
        magd    = det_abs[MAGD_W-1:0];
        rnd     = {1'b0, magd} + ((MAGD_W+1)'(1) << (SH - 1));
        rnd_sh  = rnd >> SH;
        for (int k = 0; k < LANES; k++)
        begin
            cabs[k] = cof4_reg[k][NW-1] ? -cof4_reg[k] : cof4_reg[k];
            x_c[k]  = (XW'(cabs[k][NUM_W-1:0]) << (SH + 1)) + XW'(magd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                x5_reg[k]   <= x_c[k];
                neg5_reg[k] <= cof4_reg[k][NW-1] ^ dneg;
            end
            y5_reg    <= {magd, 1'b0};
            sing5_reg <= (det_reg == '0);
            dval5_reg <= sat32(dneg, 128'(rnd_sh));
        end
    end

    // stage 6: quotient range check and first partial remainder
    always_comb
    begin
        ylim = CW'(y5_reg) << QW;
        for (int k = 0; k < LANES; k++)
        begin
            xc6[k]  = CW'(x5_reg[k]);
            rem6[k] = xc6[k] >> QW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                f6_reg.lane[k].rem <= rem6[k][YW-1:0];
                f6_reg.lane[k].xb  <= x5_reg[k][QW-1:0];
                f6_reg.lane[k].q   <= '0;
                f6_reg.lane[k].neg <= neg5_reg[k];
                f6_reg.lane[k].ovf <= (xc6[k] >= ylim);
            end
            f6_reg.y         <= y5_reg;
            f6_reg.singular  <= sing5_reg;
            f6_reg.det_value <= dval5_reg;
        end
    end

    assign dout = f6_reg;

endmodule

// ===== rtl/core/m3i_div_stage.sv =====
// ----------------------------------------------------------------------------
// m3i_div_stage: one restoring division step for all nine lanes
// Shifts in one dividend bit, subtracts the divisor where it fits.
// ----------------------------------------------------------------------------
module m3i_div_stage (
    input  logic                clk,
    input  logic                en,
    input  m3i_pkg::div_word_t  din,
    output m3i_pkg::div_word_t  dout
);
    import m3i_pkg::*;

    div_word_t     word_reg;
    div_word_t     word_next;
    logic [YW:0]   t [LANES];
    logic [YW:0]   r [LANES];
    logic          ge [LANES];

    // compare and subtract per lane
    always_comb
    begin
        word_next = din;
        for (int k = 0; k < LANES; k++)
        begin
            t[k]  = {din.lane[k].rem, din.lane[k].xb[QW-1]};
            ge[k] = (t[k] >= {1'b0, din.y});
            r[k]  = ge[k] ? (t[k] - {1'b0, din.y}) : t[k];
            word_next.lane[k].rem = r[k][YW-1:0];
            word_next.lane[k].xb  = {din.lane[k].xb[QW-2:0], 1'b0};
            word_next.lane[k].q   = {din.lane[k].q[QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

// ===== rtl/core/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 inverse by the adjugate, signed fixed point
// Determinant, nine cofactors and nine pipelined divisions.
// ----------------------------------------------------------------------------
// Usage:
//   matrix  - sink channel, one beat is a whole matrix m00..m22 (Q16.16).
//   inverse - source channel, one beat is inv00..inv22, det_value and
//             singular. Every matrix gives exactly one result, in order.
//   Throughput is one matrix per cycle unless the full output buffer
//   holds the pipeline. A result passes seven cofactor/determinant
//   stages, then one stage per quotient bit of the 33-bit restoring divider.
//   A two-beat output buffer parts the channels: matrices keep being taken
//   while one result waits; once both entries are full the whole pipeline
//   holds and matrix.ready drops, and nothing is lost or repeated.
//   A zero determinant gives singular high with all other fields zero;
//   out-of-range values saturate to 32 bits.
//   Reset clears the stage valid bits and the output buffer count; no state
//   otherwise.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    m3i_stream_if.sink    matrix,
    m3i_stream_if.source  inverse
);
    import m3i_pkg::*;

    localparam int NST = 7 + QW;

    logic               en;
    logic [NST-1:0]     vld_reg;
    div_word_t          w [QW+1];
    div_word_t          last;
    logic [DW-1:0]      inv_v [LANES];
    out_t               res;
    logic               push;
    logic               pop;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    out_t               buf0_reg;
    out_t               buf1_reg;

    assign en           = (cnt_reg != 2'd2);
    assign matrix.ready = en;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], matrix.valid};
        end
    end

    m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk  (clk),
        .en   (en),
        .din  (matrix.data),
        .dout (w[0])
    );

    // divider, one quotient bit per stage
    for (genvar g = 0; g < QW; g++)
    begin : g_div
        m3i_div_stage u_stage (
            .clk  (clk),
            .en   (en),
            .din  (w[g]),
            .dout (w[g+1])
        );
    end

    assign last = w[QW];

    // clamp and zero on a singular matrix
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            inv_v[k] = last.singular ? '0
                     : sat32(last.lane[k].neg, 128'({last.lane[k].ovf, last.lane[k].q}));
        end
        res.inv00     = inv_v[0];
        res.inv01     = inv_v[1];
        res.inv02     = inv_v[2];
        res.inv10     = inv_v[3];
        res.inv11     = inv_v[4];
        res.inv12     = inv_v[5];
        res.inv20     = inv_v[6];
        res.inv21     = inv_v[7];
        res.inv22     = inv_v[8];
        res.det_value = last.singular ? '0 : last.det_value;
        res.singular  = last.singular;
    end

    // two-beat output buffer, entry 0 is the head
    assign push = en && vld_reg[NST-1];
    assign pop  = (cnt_reg != 2'd0) && inverse.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf0_reg <= (push && cnt_reg == 2'd1) ? res : buf1_reg;
        end
        else if (push && cnt_reg == 2'd0)
        begin
            buf0_reg <= res;
        end
        if (push && !pop && cnt_reg == 2'd1)
        begin
            buf1_reg <= res;
        end
    end

    assign inverse.valid = (cnt_reg != 2'd0);
    assign inverse.data  = buf0_reg;

    // buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // a full buffer holds the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (!push && !matrix.ready))
        else $error("beat pushed into a full output buffer");

    // singular results carry zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (inverse.valid && inverse.data.singular) |->
        (inverse.data.det_value == '0 && inverse.data.inv00 == '0 &&
         inverse.data.inv22 == '0))
        else $error("singular result with nonzero fields");

endmodule
